FILE: design/stii_pkg.sv
// Shared types, codes and helpers for the sorted table interpolator/integrator.
package stii_pkg;

  localparam int STII_TABLE_DEPTH = 64;
  localparam int STII_FRAC_BITS   = 16;
  localparam int DATA_W           = 32;
  localparam int BW_W             = 31;
  // doubled positions and keys, with headroom for edge arithmetic
  localparam int P2_W             = 36;
  localparam int ACC_W            = 72;
  localparam int MUL_A_W          = 34;
  localparam int MUL_B_W          = 18;
  localparam int MUL_P_W          = MUL_A_W + MUL_B_W + 1;
  localparam int DIV_STEPS        = 32;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_INSERT   = 2'd1,
    OP_VALUE    = 2'd2,
    OP_INTEGRAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_LB_TEST,
    S_LB_CMP,
    S_INS_CHK,
    S_INS_EQ,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_VA_DONE,
    S_VAL_GO,
    S_VAL_RDHI,
    S_VAL_HI,
    S_VAL_LO,
    S_VAL_DIV,
    S_VAL_M0,
    S_VAL_M1,
    S_VAL_M2,
    S_BI_LB2,
    S_BI_RD0,
    S_BI_CHK,
    S_BI_MID,
    S_TERM0,
    S_TERM1,
    S_TERM2,
    S_BI_FIRST_RD,
    S_BI_FIRST,
    S_BI_AFTER1,
    S_BI_WALK,
    S_BI_STEP,
    S_BI_TAIL,
    S_BI_LAST,
    S_BI_LASTT,
    S_BI_FINISH,
    S_PUSH
  } state_t;

  // twice a Q16.16 value, sign extended to the doubled-position width
  function automatic logic signed [P2_W-1:0] dbl(input logic signed [DATA_W-1:0] k);
    return {{(P2_W-DATA_W-1){k[DATA_W-1]}}, k, 1'b0};
  endfunction

endpackage

FILE: design/sorted_table_interp_integrate_core.sv
// Sorted key/value table with interpolation and trapezoid bin integration.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready | opcode, point_key, point_value,
//          |           |                     | query_position, bin_width
//  out     | output    | out_valid/out_ready | answer, status, entry_count
//
// One word at a time; in_ready is high only while the sequencer is idle.
// Value-at time is set by the binary search over the key memory port and the 32-step
// divider; integral runs two searches and up to two value-at passes, plus a
// multiply-accumulate term per table point inside the bin.
// Reset clears the point count and the output valid; table memories are not cleared.
// A result waiting on out_ready does not block the next accepted word until its own push.
module sorted_table_interp_integrate_core
  import stii_pkg::*;
#(
  parameter int TABLE_DEPTH = STII_TABLE_DEPTH,
  parameter int FRAC_BITS   = STII_FRAC_BITS,
  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic signed [DATA_W-1:0] point_key,
  input  logic signed [DATA_W-1:0] point_value,
  input  logic signed [DATA_W-1:0] query_position,
  input  logic [BW_W-1:0]          bin_width,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] answer,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         entry_count
);

  localparam int SH = FRAC_BITS + 2;

  // table memories
  logic signed [DATA_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] val_mem [TABLE_DEPTH];
  logic [AW-1:0]            rd_addr, wr_addr;
  logic                     wr_key_en, wr_val_en;
  logic signed [DATA_W-1:0] wr_key, wr_val;
  logic signed [DATA_W-1:0] rd_key, rd_val;

  always_ff @(posedge clk) begin
    if (wr_key_en) key_mem[wr_addr] <= wr_key;
    if (wr_val_en) val_mem[wr_addr] <= wr_val;
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  // shared multiplier, registered
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  always_ff @(posedge clk) begin
    mul_p <= MUL_P_W'(mul_a) * MUL_P_W'($signed({1'b0, mul_b}));
  end

  // sequencer registers
  state_t state, state_next;
  state_t lb_ret, lb_ret_next, val_ret, val_ret_next, term_ret, term_ret_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] lb_lo, lb_lo_next, lb_hi, lb_hi_next;
  logic signed [P2_W-1:0] lb_p2, lb_p2_next, val_p2, val_p2_next;
  logic signed [DATA_W-1:0] val_res, val_res_next;
  logic signed [DATA_W-1:0] hi_key, hi_key_next, hi_val, hi_val_next;
  logic [MUL_A_W-1:0] div_rem, div_rem_next, div_den, div_den_next;
  logic [DIV_STEPS-1:0] div_q, div_q_next;
  logic [$clog2(DIV_STEPS)-1:0] div_cnt, div_cnt_next;
  logic signed [DATA_W:0] diff, diff_next;
  logic signed [ACC_W-1:0] ip_acc, ip_acc_next, acc, acc_next;
  logic signed [MUL_A_W-1:0] t_s, t_s_next;
  logic [P2_W-1:0] t_w, t_w_next;
  logic [CNT_W-1:0] cur, cur_next, b_lo, b_lo_next, b_up, b_up_next, j, j_next;
  logic signed [DATA_W-1:0] cur_key, cur_key_next, cur_val, cur_val_next;
  logic signed [P2_W-1:0] b_from2, b_from2_next, b_to2, b_to2_next, b_pos2, b_pos2_next;
  logic [BW_W-1:0] bw, bw_next;
  logic signed [DATA_W-1:0] key_in, key_in_next, val_in, val_in_next;
  logic signed [DATA_W-1:0] res_answer, res_answer_next;
  status_t res_status, res_status_next;
  logic out_valid_next;
  logic signed [DATA_W-1:0] answer_next;
  logic [1:0] status_next;
  logic [CNT_W-1:0] entry_count_next;

  // datapath helpers
  logic [CNT_W:0]           lb_sum, cur_inc;
  logic [CNT_W-1:0]         lb_mid;
  logic signed [P2_W-1:0]   rd_key2, num_full, first_w, walk_w, tail_w, pos_lo, pos_hi;
  logic [MUL_A_W:0]         div_rem2;
  logic                     div_ge;
  logic signed [ACC_W-1:0]  ip_full, acc_lo_add, acc_hi_add, acc_sh;
  logic [MUL_A_W-1:0]       val_sum;
  logic signed [MUL_A_W-1:0] dk;
  logic signed [DATA_W:0]   vdiff, first_s, walk_s, last_s;
  logic                     sat_hi, sat_lo;

  assign lb_sum     = {1'b0, lb_lo} + {1'b0, lb_hi};
  assign lb_mid     = lb_sum[CNT_W:1];
  assign cur_inc    = {1'b0, cur} + (CNT_W+1)'(1);
  assign rd_key2    = dbl(rd_key);
  assign num_full   = dbl(hi_key) - val_p2;
  assign dk         = {{2{hi_key[DATA_W-1]}}, hi_key} - {{2{rd_key[DATA_W-1]}}, rd_key};
  assign vdiff      = {rd_val[DATA_W-1], rd_val} - {hi_val[DATA_W-1], hi_val};
  assign div_rem2   = {div_rem, 1'b0};
  assign div_ge     = div_rem2 >= {1'b0, div_den};
  assign ip_full    = ip_acc + (ACC_W'(mul_p) <<< MUL_B_W);
  assign val_sum    = {{2{hi_val[DATA_W-1]}}, hi_val} + ip_full[2*DATA_W+1:DATA_W];
  assign acc_lo_add = acc + ACC_W'(mul_p);
  assign acc_hi_add = acc + (ACC_W'(mul_p) <<< MUL_B_W);
  assign acc_sh     = acc >>> SH;
  assign sat_hi     = !acc_sh[ACC_W-1] && (|acc_sh[ACC_W-2:DATA_W-1]);
  assign sat_lo     = acc_sh[ACC_W-1] && !(&acc_sh[ACC_W-2:DATA_W-1]);
  assign first_w    = rd_key2 - b_from2;
  assign walk_w     = rd_key2 - dbl(cur_key);
  assign tail_w     = b_to2 - dbl(cur_key);
  assign first_s    = {val_res[DATA_W-1], val_res} + {rd_val[DATA_W-1], rd_val};
  assign walk_s     = {cur_val[DATA_W-1], cur_val} + {rd_val[DATA_W-1], rd_val};
  assign last_s     = {cur_val[DATA_W-1], cur_val} + {val_res[DATA_W-1], val_res};
  assign pos_lo     = dbl(query_position) - $signed({{(P2_W-BW_W){1'b0}}, bin_width});
  assign pos_hi     = dbl(query_position) + $signed({{(P2_W-BW_W){1'b0}}, bin_width});

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    lb_ret_next      = lb_ret;
    val_ret_next     = val_ret;
    term_ret_next    = term_ret;
    cnt_next         = cnt;
    lb_lo_next       = lb_lo;
    lb_hi_next       = lb_hi;
    lb_p2_next       = lb_p2;
    val_p2_next      = val_p2;
    val_res_next     = val_res;
    hi_key_next      = hi_key;
    hi_val_next      = hi_val;
    div_rem_next     = div_rem;
    div_den_next     = div_den;
    div_q_next       = div_q;
    div_cnt_next     = div_cnt;
    diff_next        = diff;
    ip_acc_next      = ip_acc;
    acc_next         = acc;
    t_s_next         = t_s;
    t_w_next         = t_w;
    cur_next         = cur;
    b_lo_next        = b_lo;
    b_up_next        = b_up;
    j_next           = j;
    cur_key_next     = cur_key;
    cur_val_next     = cur_val;
    b_from2_next     = b_from2;
    b_to2_next       = b_to2;
    b_pos2_next      = b_pos2;
    bw_next          = bw;
    key_in_next      = key_in;
    val_in_next      = val_in;
    res_answer_next  = res_answer;
    res_status_next  = res_status;
    out_valid_next   = out_valid && !out_ready;
    answer_next      = answer;
    status_next      = status;
    entry_count_next = entry_count;
    rd_addr          = '0;
    wr_addr          = '0;
    wr_key_en        = 1'b0;
    wr_val_en        = 1'b0;
    wr_key           = key_in;
    wr_val           = val_in;
    mul_a            = t_s;
    mul_b            = t_w[MUL_B_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_in_next     = point_key;
          val_in_next     = point_value;
          bw_next         = bin_width;
          b_pos2_next     = dbl(query_position);
          b_from2_next    = pos_lo;
          b_to2_next      = pos_hi;
          res_answer_next = '0;
          res_status_next = STAT_OK;
          acc_next        = '0;
          lb_lo_next      = '0;
          lb_hi_next      = cnt;
          case (op_t'(opcode))
            OP_CLEAR: begin
              cnt_next   = '0;
              state_next = S_PUSH;
            end
            OP_INSERT: begin
              lb_p2_next  = dbl(point_key);
              lb_ret_next = S_INS_CHK;
              state_next  = S_LB_TEST;
            end
            OP_VALUE: begin
              val_p2_next  = dbl(query_position);
              val_ret_next = S_VA_DONE;
              state_next   = S_VAL_GO;
            end
            OP_INTEGRAL: begin
              lb_p2_next  = pos_lo;
              lb_ret_next = S_BI_LB2;
              state_next  = S_LB_TEST;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // binary search: first index whose doubled key is not below lb_p2
      S_LB_TEST: begin
        rd_addr = lb_mid[AW-1:0];
        if (lb_lo < lb_hi) state_next = S_LB_CMP;
        else state_next = lb_ret;
      end
      S_LB_CMP: begin
        if (rd_key2 < lb_p2) lb_lo_next = lb_mid + CNT_W'(1);
        else lb_hi_next = lb_mid;
        state_next = S_LB_TEST;
      end

      S_INS_CHK: begin
        rd_addr    = lb_lo[AW-1:0];
        state_next = S_INS_EQ;
      end
      S_INS_EQ: begin
        if (lb_lo < cnt && rd_key == key_in) begin
          wr_addr    = lb_lo[AW-1:0];
          wr_val_en  = 1'b1;
          state_next = S_PUSH;
        end else if (cnt == CNT_W'(TABLE_DEPTH)) begin
          res_status_next = STAT_FULL;
          state_next      = S_PUSH;
        end else begin
          j_next     = cnt;
          state_next = S_SHIFT_RD;
        end
      end
      // move entries up one slot from the top down to the insert point
      S_SHIFT_RD: begin
        rd_addr = j[AW-1:0] - AW'(1);
        if (j > lb_lo) begin
          state_next = S_SHIFT_WR;
        end else begin
          wr_addr    = lb_lo[AW-1:0];
          wr_key_en  = 1'b1;
          wr_val_en  = 1'b1;
          cnt_next   = cnt + CNT_W'(1);
          state_next = S_PUSH;
        end
      end
      S_SHIFT_WR: begin
        wr_addr    = j[AW-1:0];
        wr_key_en  = 1'b1;
        wr_val_en  = 1'b1;
        wr_key     = rd_key;
        wr_val     = rd_val;
        j_next     = j - CNT_W'(1);
        state_next = S_SHIFT_RD;
      end

      S_VA_DONE: begin
        res_answer_next = val_res;
        state_next      = S_PUSH;
      end

      // interpolated value at doubled position val_p2
      S_VAL_GO: begin
        lb_lo_next  = '0;
        lb_hi_next  = cnt;
        lb_p2_next  = val_p2;
        lb_ret_next = S_VAL_RDHI;
        state_next  = S_LB_TEST;
      end
      S_VAL_RDHI: begin
        rd_addr    = lb_lo[AW-1:0];
        state_next = S_VAL_HI;
      end
      S_VAL_HI: begin
        rd_addr     = lb_lo[AW-1:0] - AW'(1);
        hi_key_next = rd_key;
        hi_val_next = rd_val;
        if (lb_lo < cnt && rd_key2 == val_p2) begin
          val_res_next = rd_val;
          state_next   = val_ret;
        end else if (lb_lo == '0 || lb_lo >= cnt) begin
          val_res_next = '0;
          state_next   = val_ret;
        end else begin
          state_next = S_VAL_LO;
        end
      end
      S_VAL_LO: begin
        div_rem_next = num_full[MUL_A_W-1:0];
        div_den_next = {dk[MUL_A_W-2:0], 1'b0};
        div_q_next   = '0;
        div_cnt_next = '0;
        diff_next    = vdiff;
        state_next   = S_VAL_DIV;
      end
      S_VAL_DIV: begin
        div_rem_next = div_ge ? MUL_A_W'(div_rem2 - {1'b0, div_den})
                              : div_rem2[MUL_A_W-1:0];
        div_q_next   = {div_q[DIV_STEPS-2:0], div_ge};
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == $clog2(DIV_STEPS)'(DIV_STEPS - 1)) state_next = S_VAL_M0;
      end
      S_VAL_M0: begin
        mul_a      = MUL_A_W'(diff);
        mul_b      = div_q[MUL_B_W-1:0];
        state_next = S_VAL_M1;
      end
      S_VAL_M1: begin
        mul_a       = MUL_A_W'(diff);
        mul_b       = MUL_B_W'(div_q[DIV_STEPS-1:MUL_B_W]);
        ip_acc_next = ACC_W'(mul_p);
        state_next  = S_VAL_M2;
      end
      S_VAL_M2: begin
        val_res_next = val_sum[DATA_W-1:0];
        state_next   = val_ret;
      end

      // bin integral
      S_BI_LB2: begin
        b_lo_next   = lb_lo;
        lb_lo_next  = '0;
        lb_hi_next  = cnt;
        lb_p2_next  = b_to2;
        lb_ret_next = S_BI_RD0;
        state_next  = S_LB_TEST;
      end
      S_BI_RD0: begin
        b_up_next  = lb_lo;
        rd_addr    = '0;
        state_next = S_BI_CHK;
      end
      S_BI_CHK: begin
        if (b_lo >= cnt || b_to2 < rd_key2) begin
          state_next = S_PUSH;
        end else if (b_lo == b_up && b_up != '0) begin
          val_p2_next  = b_pos2;
          val_ret_next = S_BI_MID;
          state_next   = S_VAL_GO;
        end else begin
          val_p2_next  = b_from2;
          val_ret_next = S_BI_FIRST_RD;
          state_next   = S_VAL_GO;
        end
      end
      S_BI_MID: begin
        t_s_next      = {val_res[DATA_W-1], val_res, 1'b0};
        t_w_next      = {{(P2_W-BW_W-1){1'b0}}, bw, 1'b0};
        term_ret_next = S_BI_FINISH;
        state_next    = S_TERM0;
      end
      // accumulate t_s * t_w in two partial products
      S_TERM0: begin
        state_next = S_TERM1;
      end
      S_TERM1: begin
        mul_b      = t_w[2*MUL_B_W-1:MUL_B_W];
        acc_next   = acc_lo_add;
        state_next = S_TERM2;
      end
      S_TERM2: begin
        acc_next   = acc_hi_add;
        state_next = term_ret;
      end
      S_BI_FIRST_RD: begin
        rd_addr    = b_lo[AW-1:0];
        state_next = S_BI_FIRST;
      end
      S_BI_FIRST: begin
        cur_next      = b_lo;
        cur_key_next  = rd_key;
        cur_val_next  = rd_val;
        t_s_next      = MUL_A_W'(first_s);
        t_w_next      = first_w;
        term_ret_next = S_BI_AFTER1;
        state_next    = S_TERM0;
      end
      S_BI_AFTER1: begin
        if (b_up == '0) state_next = S_BI_FINISH;
        else state_next = S_BI_WALK;
      end
      S_BI_WALK: begin
        rd_addr = cur_inc[AW-1:0];
        if (cur == b_up || cur_inc >= {1'b0, cnt}) state_next = S_BI_TAIL;
        else state_next = S_BI_STEP;
      end
      S_BI_STEP: begin
        if (rd_key2 > b_to2) begin
          state_next = S_BI_TAIL;
        end else begin
          t_s_next      = MUL_A_W'(walk_s);
          t_w_next      = walk_w;
          cur_key_next  = rd_key;
          cur_val_next  = rd_val;
          cur_next      = cur_inc[CNT_W-1:0];
          term_ret_next = S_BI_WALK;
          state_next    = S_TERM0;
        end
      end
      S_BI_TAIL: begin
        rd_addr = b_up[AW-1:0] - AW'(1);
        if (dbl(cur_key) == b_to2) state_next = S_BI_FINISH;
        else state_next = S_BI_LAST;
      end
      S_BI_LAST: begin
        cur_key_next = rd_key;
        cur_val_next = rd_val;
        val_p2_next  = b_to2;
        val_ret_next = S_BI_LASTT;
        state_next   = S_VAL_GO;
      end
      S_BI_LASTT: begin
        t_s_next      = MUL_A_W'(last_s);
        t_w_next      = tail_w;
        term_ret_next = S_BI_FINISH;
        state_next    = S_TERM0;
      end
      S_BI_FINISH: begin
        if (sat_hi) begin
          res_answer_next = {1'b0, {(DATA_W-1){1'b1}}};
          res_status_next = STAT_SAT;
        end else if (sat_lo) begin
          res_answer_next = {1'b1, {(DATA_W-1){1'b0}}};
          res_status_next = STAT_SAT;
        end else begin
          res_answer_next = acc_sh[DATA_W-1:0];
        end
        state_next = S_PUSH;
      end

      // hand the result to the output register once it is free
      S_PUSH: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          answer_next      = res_answer;
          status_next      = res_status;
          entry_count_next = cnt;
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lb_ret      <= lb_ret_next;
    val_ret     <= val_ret_next;
    term_ret    <= term_ret_next;
    lb_lo       <= lb_lo_next;
    lb_hi       <= lb_hi_next;
    lb_p2       <= lb_p2_next;
    val_p2      <= val_p2_next;
    val_res     <= val_res_next;
    hi_key      <= hi_key_next;
    hi_val      <= hi_val_next;
    div_rem     <= div_rem_next;
    div_den     <= div_den_next;
    div_q       <= div_q_next;
    div_cnt     <= div_cnt_next;
    diff        <= diff_next;
    ip_acc      <= ip_acc_next;
    acc         <= acc_next;
    t_s         <= t_s_next;
    t_w         <= t_w_next;
    cur         <= cur_next;
    b_lo        <= b_lo_next;
    b_up        <= b_up_next;
    j           <= j_next;
    cur_key     <= cur_key_next;
    cur_val     <= cur_val_next;
    b_from2     <= b_from2_next;
    b_to2       <= b_to2_next;
    b_pos2      <= b_pos2_next;
    bw          <= bw_next;
    key_in      <= key_in_next;
    val_in      <= val_in_next;
    res_answer  <= res_answer_next;
    res_status  <= res_status_next;
    answer      <= answer_next;
    status      <= status_next;
    entry_count <= entry_count_next;
  end

endmodule

FILE: tb/sorted_table_interp_integrate_core_tb.sv
// Self-checking testbench for the sorted table interpolator and bin integrator core.
module sorted_table_interp_integrate_core_tb;
  import stii_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = STII_TABLE_DEPTH;
  localparam int RAND_ITEMS  = 1450;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [31:0] answer;
    logic [1:0]  status;
    logic [6:0]  count;
  } result_t;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [31:0] val;
    logic [31:0] pos;
    logic [30:0] bw;
    bit          typed;
    result_t     res;
  } word_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] opcode;
  logic signed [31:0] point_key, point_value, query_position;
  logic [30:0] bin_width;
  logic signed [31:0] answer;
  logic [1:0] status;
  logic [6:0] entry_count;

  sorted_table_interp_integrate_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .point_key(point_key), .point_value(point_value),
    .query_position(query_position), .bin_width(bin_width),
    .out_valid(out_valid), .out_ready(out_ready), .answer(answer),
    .status(status), .entry_count(entry_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // shadow copy of the table
  longint tbl_key[DEPTH];
  longint tbl_val[DEPTH];
  int     tbl_n;
  longint acc_hi, acc_lo;

  function automatic int lower_idx2(longint p2);
    int i = 0;
    while (i < tbl_n && 2 * tbl_key[i] < p2) i++;
    return i;
  endfunction

  function automatic longint unsigned weight_div(longint unsigned num, longint unsigned den);
    longint unsigned rem = num, q = 0;
    for (int b = 0; b < 32; b++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint interp2(longint p2);
    int i = lower_idx2(p2);
    longint diff, num, den;
    longint unsigned w;
    if (i < tbl_n && 2 * tbl_key[i] == p2) return tbl_val[i];
    if (i == 0 || i >= tbl_n) return 0;
    num = 2 * tbl_key[i] - p2;
    den = 2 * (tbl_key[i] - tbl_key[i-1]);
    w = weight_div(num, den);
    diff = tbl_val[i-1] - tbl_val[i];
    return tbl_val[i] + ((diff * longint'(w >> 16) + ((diff * longint'(w & 64'hFFFF)) >>> 16))
                         >>> 16);
  endfunction

  function automatic void add_area(longint s, longint w);
    acc_hi += s * (w >>> 16);
    acc_lo += s * (w & 64'hFFFF);
  endfunction

  function automatic longint close_area(ref bit sat);
    longint c = acc_hi + (acc_lo >>> 16);
    longint q = c >>> (STII_FRAC_BITS + 2 - 16);
    if (q > 64'sh7FFFFFFF) begin
      sat = 1;
      return 64'sh7FFFFFFF;
    end
    if (q < -64'sh80000000) begin
      sat = 1;
      return -64'sh80000000;
    end
    return q;
  endfunction

  function automatic longint bin_area(longint pos, longint bw, ref bit sat);
    longint from2 = 2 * pos - bw, to2 = 2 * pos + bw;
    int lo, up, cur, last;
    acc_hi = 0;
    acc_lo = 0;
    lo = lower_idx2(from2);
    up = lower_idx2(to2);
    if (lo >= tbl_n || to2 < 2 * tbl_key[0]) return 0;
    if (lo == up && up != 0) begin
      add_area(2 * interp2(2 * pos), 2 * bw);
      return close_area(sat);
    end
    add_area(interp2(from2) + tbl_val[lo], 2 * tbl_key[lo] - from2);
    if (up == 0) return close_area(sat);
    cur = lo;
    while (cur != up) begin
      if (cur + 1 >= tbl_n) break;
      if (2 * tbl_key[cur+1] > to2) break;
      add_area(tbl_val[cur] + tbl_val[cur+1], 2 * (tbl_key[cur+1] - tbl_key[cur]));
      cur++;
    end
    if (cur < tbl_n && 2 * tbl_key[cur] == to2) return close_area(sat);
    last = up - 1;
    add_area(tbl_val[last] + interp2(to2), to2 - 2 * tbl_key[last]);
    return close_area(sat);
  endfunction

  function automatic result_t table_step(word_t w);
    result_t r;
    longint key = longint'($signed(w.key));
    longint pos = longint'($signed(w.pos));
    longint ans = 0;
    bit sat = 0;
    int i;
    r.status = STAT_OK;
    case (w.op)
      OP_CLEAR: tbl_n = 0;
      OP_INSERT: begin
        i = lower_idx2(2 * key);
        if (i < tbl_n && tbl_key[i] == key) begin
          tbl_val[i] = longint'($signed(w.val));
        end else if (tbl_n >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (int j = tbl_n; j > i; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_val[j] = tbl_val[j-1];
          end
          tbl_key[i] = key;
          tbl_val[i] = longint'($signed(w.val));
          tbl_n++;
        end
      end
      OP_VALUE: ans = interp2(2 * pos);
      default: begin
        ans = bin_area(pos, longint'({33'd0, w.bw}), sat);
        if (sat) r.status = STAT_SAT;
      end
    endcase
    r.answer = ans[31:0];
    r.count = tbl_n[6:0];
    return r;
  endfunction

  word_t   words[$];
  result_t expected_q[$];
  int      fails = 0;
  int      mismatches = 0;
  int      sent = 0, accepted = 0, total = 0;
  int      snd_idle = 35, rcv_idle = 67;
  longint  cycles = 0;

  function automatic void add_word(op_t op, logic [31:0] key, logic [31:0] val,
                                   logic [31:0] pos, logic [30:0] bw);
    word_t w;
    w.op = op; w.key = key; w.val = val; w.pos = pos; w.bw = bw; w.typed = 0; w.res = '0;
    words.push_back(w);
  endfunction

  function automatic void add_typed(op_t op, logic [31:0] key, logic [31:0] val,
                                    logic [31:0] pos, logic [30:0] bw, result_t res);
    add_word(op, key, val, pos, bw);
    words[$].typed = 1;
    words[$].res = res;
  endfunction

  // keys on a coarse grid so inserts collide and queries land inside the table
  function automatic logic [31:0] grid_key();
    if ($urandom_range(9) == 0) return $urandom;
    return ($urandom_range(80) << $urandom_range(12, 16)) - 32'h00280000;
  endfunction

  function automatic logic [30:0] rand_bw();
    case ($urandom_range(9))
      0: return '0;
      1: return 31'($urandom);
      2: return 31'h7FFFFFFF;
      default: return 31'($urandom_range(1, 32'h00100000));
    endcase
  endfunction

  function automatic void build_stimulus();
    int n, base;
    // directed rows
    add_typed(OP_VALUE, 0, 0, 0, 0, '{32'd0, STAT_OK, 7'd0});
    add_typed(OP_INTEGRAL, 0, 0, 0, 31'h7FFFFFFF, '{32'd0, STAT_OK, 7'd0});
    add_typed(OP_INSERT, 32'h80000000, 32'h7FFFFFFF, 0, 0, '{32'd0, STAT_OK, 7'd1});
    add_typed(OP_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, '{32'd0, STAT_OK, 7'd2});
    add_word(OP_INTEGRAL, 0, 0, 0, 31'h7FFFFFFF);
    add_word(OP_VALUE, 0, 0, 0, 0);
    add_word(OP_INSERT, 0, 32'h80000000, 0, 0);
    add_word(OP_VALUE, 0, 0, 0, 0);
    add_word(OP_VALUE, 0, 0, 32'h40000000, 0);
    add_word(OP_INTEGRAL, 0, 0, 32'h12345678, 0);
    add_word(OP_INTEGRAL, 0, 0, 32'h20000000, 31'h00010000);
    add_word(OP_INTEGRAL, 0, 0, 32'h80000000, 31'h00000000);
    add_word(OP_INSERT, 0, 32'h00050000, 0, 0);
    add_word(OP_INTEGRAL, 0, 0, 0, 31'h7FFFFFFF);
    add_word(OP_VALUE, 0, 0, 32'h80000000, 0);
    add_word(OP_VALUE, 0, 0, 32'h7FFFFFFF, 0);
    add_typed(OP_CLEAR, 0, 0, 0, 0, '{32'd0, STAT_OK, 7'd0});
    add_typed(OP_INSERT, 32'h00010000, 32'h00010000, 0, 0, '{32'd0, STAT_OK, 7'd1});
    add_word(OP_INSERT, 32'h00030000, 32'hFFFE0000, 0, 0);
    add_word(OP_INTEGRAL, 0, 0, 32'h00020000, 31'h00040000);
    add_word(OP_INTEGRAL, 0, 0, 0, 31'h00010000);
    add_word(OP_INTEGRAL, 0, 0, 32'h00020000, 31'h00010000);
    add_word(OP_VALUE, 0, 0, 32'h0002FFFF, 0);
    base = words.size();
    // random part: mostly fill-then-query sequences, with some raw noise
    while (words.size() < base + RAND_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        add_word(op_t'($urandom_range(3)), $urandom, $urandom, $urandom, 31'($urandom));
      end else begin
        if ($urandom_range(3) != 0)
          add_word(OP_CLEAR, $urandom, $urandom, $urandom, 31'($urandom));
        if ($urandom_range(11) == 0) begin
          // overfill with distinct keys, then overwrite one while full
          n = $urandom_range(66, 72);
          for (int k = 0; k < n; k++)
            add_word(OP_INSERT, (k - 30) << 15, $urandom, $urandom, 31'($urandom));
          add_word(OP_INSERT, 32'h00000000, $urandom, $urandom, 31'($urandom));
        end else begin
          n = $urandom_range(1, 16);
          for (int k = 0; k < n; k++)
            add_word(OP_INSERT, grid_key(), $urandom_range(1) ? $urandom :
                     ($urandom_range(64) << 14) - 32'h00080000, $urandom, 31'($urandom));
        end
        n = $urandom_range(3, 12);
        for (int k = 0; k < n; k++)
          add_word($urandom_range(1) ? OP_VALUE : OP_INTEGRAL, $urandom, $urandom,
                   grid_key() + $urandom_range(32'h7FFF), rand_bw());
      end
    end
  endfunction

  initial begin
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    opcode = OP_CLEAR;
    point_key = 0;
    point_value = 0;
    query_position = 0;
    bin_width = 0;
    tbl_n = 0;
    build_stimulus();
    total = words.size();
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) accepted++;
      if (!in_valid || in_ready) begin
        if (sent < total && $urandom_range(99) >= snd_idle) begin
          in_valid <= 1;
          opcode <= words[sent].op;
          point_key <= words[sent].key;
          point_value <= words[sent].val;
          query_position <= words[sent].pos;
          bin_width <= words[sent].bw;
          expected_q.push_back(words[sent].typed ? words[sent].res : table_step(words[sent]));
          if (words[sent].typed) void'(table_step(words[sent]));
          sent++;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver, idle profile by phase
  always @(posedge clk) begin
    if (accepted < total / 3) begin
      snd_idle = 35; rcv_idle = 67;
    end else if (accepted < 2 * total / 3) begin
      snd_idle = 67; rcv_idle = 35;
    end else begin
      snd_idle = 0; rcv_idle = 0;
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= rcv_idle);
  end

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (mismatches++ < 10) $display("unexpected word: answer %h", answer);
      end else begin
        exp_r = expected_q.pop_front();
        if (answer !== exp_r.answer || status !== exp_r.status || entry_count !== exp_r.count)
        begin
          fails++;
          if (mismatches++ < 10)
            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d", exp_r.answer, exp_r.status,
                     exp_r.count, answer, status, entry_count);
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    while (!(accepted == total && expected_q.size() == 0)) begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
    // drain: any late stray word is flagged by the checker
    repeat (600) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
